@@ hw/rtl/sws_pkg.sv @@
`timescale 1ns / 1ps

package sws_pkg;

    localparam int SAMPLE_W           = 24;
    localparam int OUT_W              = 48;
    localparam int CFG_W              = 7;
    localparam int QFRAC_W            = 17;
    localparam int PADDR_W            = 3;
    localparam int MAX_WINDOW_DEFAULT = 64;

    localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 7'd16;
    localparam logic             REG_WINDOW_LEN   = 1'b0;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SAMPLE_W-1:0] window_mean;
    } sws_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] slope;
        logic signed [OUT_W-1:0] intercept;
        logic signed [OUT_W-1:0] prediction;
    } sws_out_t;

endpackage

@@ hw/rtl/sliding_window_slope_estimator_unit.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      sws_in_t  {sample, window_mean}
// m_        out        m_valid / m_ready      sws_out_t {slope, intercept, prediction}
// apb       in         psel/penable/pready    window_len at address 0
// Each item takes a multiply-accumulate pass over the ring, one memory read per cycle,
// then the bit-serial divider (skipped for a window of one), with a handful of steps on
// the shared multiplier before and after it.
// After reset the ring is cleared one entry a cycle, all MAX_WINDOW entries; no item is
// taken meanwhile. A waiting result does not block the next item, which only stalls
// in its last step if the previous result has still not been taken.

module sliding_window_slope_estimator_unit #(
    parameter int MAX_WINDOW = sws_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  sws_pkg::sws_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output sws_pkg::sws_out_t              m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sws_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import sws_pkg::*;

    localparam int PW   = $clog2(MAX_WINDOW);
    localparam int NW   = $clog2(MAX_WINDOW + 1);
    localparam int BW   = 2 * NW;
    localparam int PRW  = OUT_W + 1 + BW;
    localparam int SXW  = SAMPLE_W + 2 * NW;
    localparam int NUMW = SAMPLE_W + 1 + 2 * NW;
    localparam int AW   = NUMW + 4;
    localparam int DW   = 3 * NW;
    localparam int QW   = AW + QFRAC_W;
    localparam int B2W  = PRW + 1;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_WRITE  = 13'b0000000000010,
        ST_MAC    = 13'b0000000000100,
        ST_NN     = 13'b0000000001000,
        ST_DEN    = 13'b0000000010000,
        ST_TM     = 13'b0000000100000,
        ST_NUM    = 13'b0000001000000,
        ST_DSTART = 13'b0000010000000,
        ST_DIV    = 13'b0000100000000,
        ST_KSET   = 13'b0001000000000,
        ST_BMUL   = 13'b0010000000000,
        ST_PMUL   = 13'b0100000000000,
        ST_FIN    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CFG_W-1:0] window_len_reg, window_len_next;
    logic [PW-1:0] write_pos_reg, write_pos_next;
    logic          m_valid_reg, m_valid_next;
    logic          rd_vld_reg, rd_vld_next;
    logic          p_vld_reg, p_vld_next;

    logic signed [SAMPLE_W-1:0] ym_reg, ym_next;
    logic signed [SAMPLE_W-1:0] smp_reg, smp_next;
    logic [NW-1:0]  n_reg, n_next;
    logic [PW-1:0]  wp_reg, wp_next;
    logic [NW-1:0]  i_reg, i_next;
    logic [NW-1:0]  xi_reg, xi_next;
    logic [NW-1:0]  xi_d_reg, xi_d_next;
    logic signed [SXW-1:0]  sxy_reg, sxy_next;
    logic signed [PRW-1:0]  prod_reg, prod_next;
    logic [BW-1:0]  nn_reg, nn_next;
    logic [DW-1:0]  d_reg, d_next;
    logic signed [NUMW-1:0] num_reg, num_next;
    logic signed [OUT_W-1:0] k_reg, k_next;
    logic signed [OUT_W-1:0] b_reg, b_next;
    sws_out_t out_reg, out_next;

    logic          mul_en;
    logic signed [OUT_W-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic          ring_we;
    logic          ring_busy;
    logic signed [SAMPLE_W-1:0] ring_rdata;
    logic          div_start;
    logic          div_done;
    logic [QW-1:0] div_q;
    logic [NUMW-1:0] mag;
    logic [AW-1:0] div_a;
    logic [NW-1:0] n_clamp;
    logic [PW-1:0] wp_adj;
    logic signed [OUT_W-1:0] k_val;
    logic signed [B2W-1:0] ym_sh;
    logic [48:0]   mq;
    logic          cfg_wr;

    function automatic logic signed [OUT_W-1:0] halve_sat(input logic signed [B2W-1:0] v);
        logic signed [B2W-1:0] h;
        if (v >= 0) begin
            h = (v + B2W'(1)) >>> 1;
        end else begin
            h = v >>> 1;
        end
        if (h > B2W'(OUT_MAX)) begin
            return OUT_MAX;
        end else if (h < B2W'(OUT_MIN)) begin
            return OUT_MIN;
        end
        return h[OUT_W-1:0];
    endfunction

    sws_ring #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_ring (
        .aclk   (aclk),
        .aresetn(aresetn),
        .we     (ring_we),
        .waddr  (wp_reg),
        .wdata  (smp_reg),
        .raddr  (i_reg[PW-1:0]),
        .rdata  (ring_rdata),
        .busy   (ring_busy)
    );

    sws_div #(
        .AW(AW),
        .DW(DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_a),
        .divisor (d_reg),
        .done    (div_done),
        .quotient(div_q)
    );

    assign s_ready = (state_reg == ST_IDLE) && !ring_busy;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LEN);
    assign prdata  = (paddr[2] == REG_WINDOW_LEN) ? {25'd0, window_len_reg} : 32'd0;

    assign mag   = num_reg[NUMW-1] ? NUMW'(-num_reg) : NUMW'(num_reg);
    assign div_a = (AW'(mag) << 3) + (AW'(mag) << 2);
    assign ym_sh = B2W'(ym_reg) <<< QFRAC_W;
    assign mq    = 49'((div_q + QW'(1)) >> 1);

    always_comb begin
        int cfg_n;
        cfg_n = int'(window_len_reg);
        if (cfg_n < 1) begin
            cfg_n = 1;
        end
        if (cfg_n > MAX_WINDOW) begin
            cfg_n = MAX_WINDOW;
        end
        n_clamp = NW'(cfg_n);
        wp_adj  = (int'(write_pos_reg) >= cfg_n) ? '0 : write_pos_reg;
    end

    always_comb begin
        if (n_reg == NW'(1)) begin
            if (num_reg == '0) begin
                k_val = OUT_W'(1);
            end else begin
                k_val = num_reg[NUMW-1] ? OUT_MIN : OUT_MAX;
            end
        end else if ((div_q >> 49) != '0) begin
            k_val = num_reg[NUMW-1] ? OUT_MIN : OUT_MAX;
        end else if (num_reg[NUMW-1]) begin
            k_val = (mq > 49'h0_8000_0000_0000) ? OUT_MIN : -$signed(mq[OUT_W-1:0]);
        end else begin
            k_val = (mq > 49'h0_7FFF_FFFF_FFFF) ? OUT_MAX : $signed(mq[OUT_W-1:0]);
        end
        if (k_val == '0) begin
            k_val = OUT_W'(1);
        end
    end

    always_comb begin
        state_next      = state_reg;
        window_len_next = cfg_wr ? pwdata[CFG_W-1:0] : window_len_reg;
        write_pos_next  = write_pos_reg;
        m_valid_next    = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        rd_vld_next     = 1'b0;
        p_vld_next      = 1'b0;
        ym_next   = ym_reg;
        smp_next  = smp_reg;
        n_next    = n_reg;
        wp_next   = wp_reg;
        i_next    = i_reg;
        xi_next   = xi_reg;
        xi_d_next = xi_d_reg;
        sxy_next  = sxy_reg;
        nn_next   = nn_reg;
        d_next    = d_reg;
        num_next  = num_reg;
        k_next    = k_reg;
        b_next    = b_reg;
        out_next  = out_reg;
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        ring_we   = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    ym_next    = s_data.window_mean;
                    smp_next   = s_data.sample;
                    n_next     = n_clamp;
                    wp_next    = wp_adj;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                ring_we  = 1'b1;
                i_next   = '0;
                xi_next  = n_reg - NW'(wp_reg);
                sxy_next = '0;
                if (int'(wp_reg) + 1 >= int'(n_reg)) begin
                    write_pos_next = '0;
                end else begin
                    write_pos_next = wp_reg + PW'(1);
                end
                state_next = ST_MAC;
            end
            ST_MAC: begin
                if (i_reg != n_reg) begin
                    rd_vld_next = 1'b1;
                    xi_d_next   = xi_reg;
                    xi_next     = (xi_reg == n_reg) ? NW'(1) : xi_reg + NW'(1);
                    i_next      = i_reg + NW'(1);
                end
                if (rd_vld_reg) begin
                    mul_en = 1'b1;
                    mul_a  = OUT_W'(ring_rdata);
                    mul_b  = BW'(xi_d_reg);
                end
                p_vld_next = rd_vld_reg;
                if (p_vld_reg) begin
                    sxy_next = sxy_reg + $signed(prod_reg[SXW-1:0]);
                end
                if (i_reg == n_reg && !rd_vld_reg && !p_vld_reg) begin
                    state_next = ST_NN;
                end
            end
            ST_NN: begin
                mul_en     = 1'b1;
                mul_a      = OUT_W'(n_reg);
                mul_b      = BW'(n_reg);
                state_next = ST_DEN;
            end
            ST_DEN: begin
                nn_next    = prod_reg[BW-1:0];
                mul_en     = 1'b1;
                mul_a      = OUT_W'(n_reg);
                mul_b      = prod_reg[BW-1:0] - BW'(1);
                state_next = ST_TM;
            end
            ST_TM: begin
                d_next     = prod_reg[DW-1:0];
                mul_en     = 1'b1;
                mul_a      = OUT_W'(ym_reg);
                mul_b      = (nn_reg + BW'(n_reg)) >> 1;
                state_next = ST_NUM;
            end
            ST_NUM: begin
                num_next   = NUMW'(sxy_reg) - $signed(prod_reg[NUMW-1:0]);
                state_next = ST_DSTART;
            end
            ST_DSTART: begin
                if (n_reg == NW'(1)) begin
                    state_next = ST_KSET;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_KSET;
                end
            end
            ST_KSET: begin
                k_next     = k_val;
                state_next = ST_BMUL;
            end
            ST_BMUL: begin
                mul_en     = 1'b1;
                mul_a      = k_reg;
                mul_b      = BW'(n_reg) + BW'(1);
                state_next = ST_PMUL;
            end
            ST_PMUL: begin
                b_next     = halve_sat(ym_sh - B2W'(prod_reg));
                mul_en     = 1'b1;
                mul_a      = k_reg;
                mul_b      = BW'(n_reg) - BW'(1);
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.slope      = k_reg;
                    out_next.intercept  = b_reg;
                    out_next.prediction = halve_sat(ym_sh + B2W'(prod_reg));
                    m_valid_next        = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        prod_next = mul_en ? PRW'(mul_a) * PRW'($signed({1'b0, mul_b})) : prod_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            window_len_reg <= WINDOW_LEN_RESET;
            write_pos_reg  <= '0;
            m_valid_reg    <= 1'b0;
            rd_vld_reg     <= 1'b0;
            p_vld_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            window_len_reg <= window_len_next;
            write_pos_reg  <= write_pos_next;
            m_valid_reg    <= m_valid_next;
            rd_vld_reg     <= rd_vld_next;
            p_vld_reg      <= p_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        ym_reg   <= ym_next;
        smp_reg  <= smp_next;
        n_reg    <= n_next;
        wp_reg   <= wp_next;
        i_reg    <= i_next;
        xi_reg   <= xi_next;
        xi_d_reg <= xi_d_next;
        sxy_reg  <= sxy_next;
        prod_reg <= prod_next;
        nn_reg   <= nn_next;
        d_reg    <= d_next;
        num_reg  <= num_next;
        k_reg    <= k_next;
        b_reg    <= b_next;
        out_reg  <= out_next;
    end

    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_busy |-> !s_ready)
        else $error("item accepted during ring clear");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide step");

    a_accept_to_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_WRITE))
        else $error("accepted item did not start the ring write");

endmodule

@@ hw/rtl/sws_ring.sv @@
`timescale 1ns / 1ps

module sws_ring #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  we,
    input  logic [$clog2(MAX_WINDOW)-1:0]         waddr,
    input  logic signed [sws_pkg::SAMPLE_W-1:0]   wdata,
    input  logic [$clog2(MAX_WINDOW)-1:0]         raddr,
    output logic signed [sws_pkg::SAMPLE_W-1:0]   rdata,
    output logic                                  busy
);
    import sws_pkg::*;

    localparam int PW = $clog2(MAX_WINDOW);

    logic signed [SAMPLE_W-1:0] mem [MAX_WINDOW];
    logic          clr_active_reg;
    logic [PW-1:0] clr_addr_reg;
    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    logic signed [SAMPLE_W-1:0] mem_wdata;

    assign busy      = clr_active_reg;
    assign mem_we    = clr_active_reg | we;
    assign mem_waddr = clr_active_reg ? clr_addr_reg : waddr;
    assign mem_wdata = clr_active_reg ? '0 : wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + PW'(1);
            if (int'(clr_addr_reg) == MAX_WINDOW - 1) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/sws_div.sv @@
`timescale 1ns / 1ps

module sws_div #(
    parameter int AW = 46,
    parameter int DW = 21
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [AW-1:0]                     dividend,
    input  logic [DW-1:0]                     divisor,
    output logic                              done,
    output logic [AW+sws_pkg::QFRAC_W-1:0]    quotient
);
    import sws_pkg::*;

    localparam int QW = AW + QFRAC_W;
    localparam int CW = $clog2(QW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] quo_reg;
    logic [DW-1:0] dsr_reg;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;

    assign shifted  = {rem_reg, quo_reg[QW-1]};
    assign diff     = shifted - {1'b0, dsr_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= {dividend, {QFRAC_W{1'b0}}};
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[DW]) begin
                rem_reg <= diff[DW-1:0];
            end else begin
                rem_reg <= shifted[DW-1:0];
            end
            quo_reg <= {quo_reg[QW-2:0], ~diff[DW]};
        end
    end

endmodule
